[hdl/lcs_pkg.sv]
// Shared types and constants for the longest common subsequence block.
// No dependencies; every other file in hdl/ refers to it by scoped name.
`timescale 1ns / 1ps

package lcs_pkg;

	localparam int MAX_LEN_DEF = 64;

	// Item op codes
	localparam logic [1:0] OP_APPEND_A = 2'd0;
	localparam logic [1:0] OP_APPEND_B = 2'd1;
	localparam logic [1:0] OP_RUN      = 2'd2;

	typedef enum logic [1:0] {
		DIR_UP   = 2'd0,
		DIR_LEFT = 2'd1,
		DIR_DIAG = 2'd2
	} dir_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL_ROW,
		ST_FILL_CELL,
		ST_TB_RD,
		ST_TB_USE,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} state_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] ch;
	} in_t;

	typedef struct packed {
		logic [7:0] ch_out;
		logic       last;
		logic       empty_res;
		logic       overflow;
	} out_t;

endpackage

[hdl/lcs_cell.sv]
// One cell of the LCS length table: match, upper and left selection.
// Depends on lcs_pkg for the direction codes.
`timescale 1ns / 1ps

module lcs_cell #(
	parameter int LW = 7
) (
	input  logic [7:0]        a,
	input  logic [7:0]        b,
	input  logic [LW-1:0]     up,
	input  logic [LW-1:0]     left,
	input  logic [LW-1:0]     diag,
	output logic [LW-1:0]     len,
	output lcs_pkg::dir_t     dir
);

	always_comb begin
		if (a == b) begin
			len = diag + LW'(1);
			dir = lcs_pkg::DIR_DIAG;
		end else if (up > left) begin
			len = up;
			dir = lcs_pkg::DIR_UP;
		end else begin
			// tie steps left
			len = left;
			dir = lcs_pkg::DIR_LEFT;
		end
	end

endmodule

[hdl/longest_common_subsequence.sv]
// Top level of the longest common subsequence block: string stores, table fill,
// traceback and result sequencing. Depends on lcs_pkg and lcs_cell.
//
//   channel   ports                    transaction when
//   -------   ----------------------   ---------------------------------------
//   input     start, busy, item        rising edge with start high, busy low
//   result    strobe, result           every cycle with strobe high (one cycle)
//
// An append item leaves busy low. A run raises busy for the table fill (one cell
// a cycle through the row buffer and direction memory, plus a row-start read),
// then the traceback (a direction memory read and a use state per step), then
// the result (an answer memory read and an output state per character).
// Reset clears lengths, flags and the sequencer; the memories need no clearing.
// The receiver cannot stall: each result shows for exactly one cycle.
`timescale 1ns / 1ps

module longest_common_subsequence #(
	parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  lcs_pkg::in_t  item,
	output logic          strobe,
	output lcs_pkg::out_t result
);

	localparam int AW        = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int LW        = $clog2(MAX_LEN + 1);
	localparam int DAW       = 2 * AW;
	localparam int DIR_DEPTH = 1 << DAW;

	lcs_pkg::state_t state_q, state_d;

	logic [LW-1:0] first_len_q, second_len_q;
	logic          dropped_q;
	logic [LW-1:0] n_q, m_q;
	logic          ovf_q;
	logic [LW-1:0] r_q, c_q;
	logic          valid_s1;
	logic [LW-1:0] c_s1;
	logic [LW-1:0] left_q, diag_q;
	logic [LW-1:0] cnt_q, em_q;
	lcs_pkg::out_t result_q;
	logic          strobe_q;

	// memories
	logic [7:0]    fs_mem  [MAX_LEN];
	logic [7:0]    ss_mem  [MAX_LEN];
	logic [7:0]    ans_mem [MAX_LEN];
	logic [LW-1:0] row_mem [MAX_LEN];
	logic [1:0]    dir_mem [DIR_DEPTH];

	logic [7:0]    fs_rd_q, ss_rd_q, ans_rd_q;
	logic [LW-1:0] row_rd_q;
	logic [1:0]    dir_rd_q;

	logic          accept;
	logic          fs_re, ss_re, row_re, dir_re, ans_re;
	logic [AW-1:0] fs_raddr;
	logic [DAW-1:0] dir_raddr;
	logic          fs_we, ss_we;
	logic          issue, row_end, tb_end;

	logic [LW-1:0] up_val, cell_len;
	lcs_pkg::dir_t cell_dir, tb_dir;
	logic [AW-1:0] r_idx, c_idx, cs1_idx;

	assign accept  = start && !busy;
	assign busy    = (state_q != lcs_pkg::ST_IDLE);
	assign strobe  = strobe_q;
	assign result  = result_q;

	assign r_idx   = AW'(r_q - LW'(1));
	assign c_idx   = AW'(c_q - LW'(1));
	assign cs1_idx = AW'(c_s1 - LW'(1));

	assign fs_we = accept && (item.op == lcs_pkg::OP_APPEND_A) && (first_len_q < LW'(MAX_LEN));
	assign ss_we = accept && (item.op == lcs_pkg::OP_APPEND_B) && (second_len_q < LW'(MAX_LEN));

	assign issue   = (state_q == lcs_pkg::ST_FILL_CELL) && (c_q <= m_q);
	assign row_end = (state_q == lcs_pkg::ST_FILL_CELL) && valid_s1 && (c_s1 == m_q);
	assign tb_end  = (r_q == '0) || (c_q == '0);
	assign tb_dir  = lcs_pkg::dir_t'(dir_rd_q);

	// the first row sees an all-zero row above it
	assign up_val = (r_q == LW'(1)) ? '0 : row_rd_q;

	lcs_cell #(
		.LW(LW)
	) u_cell (
		.a    (fs_rd_q),
		.b    (ss_rd_q),
		.up   (up_val),
		.left (left_q),
		.diag (diag_q),
		.len  (cell_len),
		.dir  (cell_dir)
	);

	// next state and memory read control
	always_comb begin
		state_d   = state_q;
		fs_re     = 1'b0;
		fs_raddr  = r_idx;
		ss_re     = 1'b0;
		row_re    = 1'b0;
		dir_re    = 1'b0;
		dir_raddr = {r_idx, c_idx};
		ans_re    = 1'b0;
		case (state_q)
			lcs_pkg::ST_IDLE: begin
				if (accept && item.op == lcs_pkg::OP_RUN) begin
					if (first_len_q != '0 && second_len_q != '0)
						state_d = lcs_pkg::ST_FILL_ROW;
					else
						state_d = lcs_pkg::ST_TB_RD;
				end
			end
			lcs_pkg::ST_FILL_ROW: begin
				fs_re   = 1'b1;
				state_d = lcs_pkg::ST_FILL_CELL;
			end
			lcs_pkg::ST_FILL_CELL: begin
				ss_re  = issue;
				row_re = issue;
				if (row_end)
					state_d = (r_q == n_q) ? lcs_pkg::ST_TB_RD : lcs_pkg::ST_FILL_ROW;
			end
			lcs_pkg::ST_TB_RD: begin
				if (tb_end) begin
					state_d = (cnt_q == '0) ? lcs_pkg::ST_IDLE : lcs_pkg::ST_EMIT_RD;
				end else begin
					fs_re   = 1'b1;
					dir_re  = 1'b1;
					state_d = lcs_pkg::ST_TB_USE;
				end
			end
			lcs_pkg::ST_TB_USE: begin
				state_d = lcs_pkg::ST_TB_RD;
			end
			lcs_pkg::ST_EMIT_RD: begin
				ans_re  = 1'b1;
				state_d = lcs_pkg::ST_EMIT_OUT;
			end
			lcs_pkg::ST_EMIT_OUT: begin
				state_d = (em_q == '0) ? lcs_pkg::ST_IDLE : lcs_pkg::ST_EMIT_RD;
			end
			default: begin
				state_d = lcs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// string stores
	always_ff @(posedge clk) begin
		if (fs_we)
			fs_mem[AW'(first_len_q)] <= item.ch;
		if (fs_re)
			fs_rd_q <= fs_mem[fs_raddr];
	end

	always_ff @(posedge clk) begin
		if (ss_we)
			ss_mem[AW'(second_len_q)] <= item.ch;
		if (ss_re)
			ss_rd_q <= ss_mem[c_idx];
	end

	// previous-row length buffer: read column c while writing column c-1
	always_ff @(posedge clk) begin
		if (valid_s1)
			row_mem[cs1_idx] <= cell_len;
		if (row_re)
			row_rd_q <= row_mem[c_idx];
	end

	always_ff @(posedge clk) begin
		if (valid_s1)
			dir_mem[{r_idx, cs1_idx}] <= cell_dir;
		if (dir_re)
			dir_rd_q <= dir_mem[dir_raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == lcs_pkg::ST_TB_USE && tb_dir == lcs_pkg::DIR_DIAG
				&& tb_dir != lcs_pkg::DIR_UP && cnt_q < LW'(MAX_LEN))
			ans_mem[AW'(cnt_q)] <= fs_rd_q;
		if (ans_re)
			ans_rd_q <= ans_mem[AW'(em_q)];
	end

	// control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_len_q  <= '0;
			second_len_q <= '0;
			dropped_q    <= 1'b0;
			n_q          <= '0;
			m_q          <= '0;
			ovf_q        <= 1'b0;
			r_q          <= '0;
			c_q          <= '0;
			valid_s1     <= 1'b0;
			c_s1         <= '0;
			left_q       <= '0;
			diag_q       <= '0;
			cnt_q        <= '0;
			em_q         <= '0;
			strobe_q     <= 1'b0;
			result_q     <= '0;
		end else begin
			strobe_q <= 1'b0;
			valid_s1 <= issue;
			if (issue)
				c_s1 <= c_q;
			case (state_q)
				lcs_pkg::ST_IDLE: begin
					if (accept) begin
						if (item.op == lcs_pkg::OP_APPEND_A) begin
							if (fs_we) first_len_q <= first_len_q + LW'(1);
							else       dropped_q   <= 1'b1;
						end else if (item.op == lcs_pkg::OP_APPEND_B) begin
							if (ss_we) second_len_q <= second_len_q + LW'(1);
							else       dropped_q    <= 1'b1;
						end else if (item.op == lcs_pkg::OP_RUN) begin
							n_q          <= first_len_q;
							m_q          <= second_len_q;
							ovf_q        <= dropped_q;
							first_len_q  <= '0;
							second_len_q <= '0;
							dropped_q    <= 1'b0;
							cnt_q        <= '0;
							if (first_len_q != '0 && second_len_q != '0) begin
								r_q <= LW'(1);
							end else begin
								r_q <= '0;
								c_q <= '0;
							end
						end
					end
				end
				lcs_pkg::ST_FILL_ROW: begin
					c_q    <= LW'(1);
					left_q <= '0;
					diag_q <= '0;
				end
				lcs_pkg::ST_FILL_CELL: begin
					if (issue)
						c_q <= c_q + LW'(1);
					if (valid_s1) begin
						left_q <= cell_len;
						diag_q <= up_val;
					end
					if (row_end) begin
						if (r_q == n_q) begin
							// hand the corner to the traceback
							c_q <= m_q;
						end else begin
							r_q <= r_q + LW'(1);
						end
					end
				end
				lcs_pkg::ST_TB_RD: begin
					if (tb_end) begin
						em_q <= cnt_q - LW'(1);
						if (cnt_q == '0) begin
							strobe_q <= 1'b1;
							result_q <= '{ch_out: 8'd0, last: 1'b1, empty_res: 1'b1,
								overflow: ovf_q};
						end
					end
				end
				lcs_pkg::ST_TB_USE: begin
					case (tb_dir)
						lcs_pkg::DIR_UP: begin
							r_q <= r_q - LW'(1);
						end
						lcs_pkg::DIR_LEFT: begin
							c_q <= c_q - LW'(1);
						end
						default: begin
							if (cnt_q < LW'(MAX_LEN))
								cnt_q <= cnt_q + LW'(1);
							r_q <= r_q - LW'(1);
							c_q <= c_q - LW'(1);
						end
					endcase
				end
				lcs_pkg::ST_EMIT_OUT: begin
					strobe_q <= 1'b1;
					result_q <= '{ch_out: ans_rd_q, last: (em_q == '0), empty_res: 1'b0,
						overflow: ovf_q};
					em_q     <= em_q - LW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	a_run_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.op == lcs_pkg::OP_RUN |=> busy)
		else $error("run transaction did not raise busy");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.empty_res |-> result.last && result.ch_out == 8'd0)
		else $error("empty result without last or with a character");

	a_fill_column_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> c_s1 != '0 && c_s1 <= m_q)
		else $error("fill stage column out of range");

	a_lengths_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> first_len_q == '0 && second_len_q == '0 && !dropped_q)
		else $error("strings not cleared after a run");

	a_no_result_mid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lcs_pkg::ST_FILL_CELL |=> !strobe)
		else $error("result issued during table fill");

endmodule

[verif/longest_common_subsequence_tb.sv]
// Self-checking testbench for longest_common_subsequence: loads string pairs,
// runs the table fill and compares every emitted character with a scoreboard.
// Depends on hdl/lcs_pkg.sv and hdl/longest_common_subsequence.sv.
`timescale 1ns / 1ps

module longest_common_subsequence_tb;

	localparam int STR_CAP = lcs_pkg::MAX_LEN_DEF;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// Generous bound, well above what a full 64 x 64 run and the rest need
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int ITEMS_PER_PHASE = 150;

	class lcs_scoreboard;
		logic [7:0]      str_a[STR_CAP];
		logic [7:0]      str_b[STR_CAP];
		int              len_a;
		int              len_b;
		bit              dropped;
		logic [6:0]      len_tab[STR_CAP + 1][STR_CAP + 1];
		lcs_pkg::dir_t   dir_tab[STR_CAP + 1][STR_CAP + 1];
		lcs_pkg::out_t   lcs_chars_due[$];
		int              errors;

		function new();
			len_a = 0;
			len_b = 0;
			dropped = 1'b0;
			errors = 0;
		endfunction

		function int pending();
			return lcs_chars_due.size();
		endfunction

		// Fill the length table, trace back from the corner, queue the answer in order
		function void solve_lcs();
			logic [7:0]    rev_chars[$];
			lcs_pkg::out_t res;
			bit            ovf;
			int            r;
			int            c;
			ovf = dropped;
			for (r = 0; r <= len_a; r++) len_tab[r][0] = '0;
			for (c = 0; c <= len_b; c++) len_tab[0][c] = '0;
			for (r = 1; r <= len_a; r++) begin
				for (c = 1; c <= len_b; c++) begin
					if (str_a[r - 1] == str_b[c - 1]) begin
						len_tab[r][c] = len_tab[r - 1][c - 1] + 7'd1;
						dir_tab[r][c] = lcs_pkg::DIR_DIAG;
					end else if (len_tab[r - 1][c] > len_tab[r][c - 1]) begin
						len_tab[r][c] = len_tab[r - 1][c];
						dir_tab[r][c] = lcs_pkg::DIR_UP;
					end else begin
						// a tie steps left
						len_tab[r][c] = len_tab[r][c - 1];
						dir_tab[r][c] = lcs_pkg::DIR_LEFT;
					end
				end
			end
			r = len_a;
			c = len_b;
			while (r > 0 && c > 0) begin
				case (dir_tab[r][c])
					lcs_pkg::DIR_UP: r--;
					lcs_pkg::DIR_LEFT: c--;
					default: begin
						rev_chars.push_back(str_a[r - 1]);
						r--;
						c--;
					end
				endcase
			end
			len_a = 0;
			len_b = 0;
			dropped = 1'b0;
			if (rev_chars.size() == 0) begin
				res = '{ch_out: 8'h00, last: 1'b1, empty_res: 1'b1, overflow: ovf};
				lcs_chars_due.push_back(res);
			end else begin
				for (int k = rev_chars.size() - 1; k >= 0; k--) begin
					res = '{ch_out: rev_chars[k], last: (k == 0), empty_res: 1'b0,
						overflow: ovf};
					lcs_chars_due.push_back(res);
				end
			end
		endfunction

		function void take_item(lcs_pkg::in_t it);
			case (it.op)
				lcs_pkg::OP_APPEND_A: begin
					if (len_a < STR_CAP) begin
						str_a[len_a] = it.ch;
						len_a++;
					end else dropped = 1'b1;
				end
				lcs_pkg::OP_APPEND_B: begin
					if (len_b < STR_CAP) begin
						str_b[len_b] = it.ch;
						len_b++;
					end else dropped = 1'b1;
				end
				lcs_pkg::OP_RUN: solve_lcs();
				default: ;
			endcase
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(lcs_pkg::out_t got);
			lcs_pkg::out_t want;
			if (lcs_chars_due.size() == 0) begin
				$error("result with none due: ch_out=%0h last=%0b empty_res=%0b overflow=%0b",
					got.ch_out, got.last, got.empty_res, got.overflow);
				errors++;
				return;
			end
			want = lcs_chars_due.pop_front();
			compare_field("ch_out", want.ch_out, got.ch_out);
			compare_field("last", 8'(want.last), 8'(got.last));
			compare_field("empty_res", 8'(want.empty_res), 8'(got.empty_res));
			compare_field("overflow", 8'(want.overflow), 8'(got.overflow));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	lcs_pkg::in_t  item = '0;
	logic strobe;
	lcs_pkg::out_t result;

	lcs_scoreboard sb = new();
	int items_sent = 0;
	int cycle_count = 0;

	longest_common_subsequence i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.strobe(strobe),
		.result(result)
	);

	always #10 clk = ~clk;

	// Check results before noting a new transaction at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe) sb.check_result(result);
			if (start && !busy) sb.take_item(item);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Hold start high until the transaction is taken
	task automatic send(logic [1:0] op, logic [7:0] ch);
		lcs_pkg::in_t it;
		it.op = op;
		it.ch = ch;
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (op != OP_UNUSED) items_sent++;
	endtask

	task automatic idle_for(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Step one edge first so the scoreboard has noted the last transaction
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic step(logic [1:0] op, logic [7:0] ch, int idle_pct);
		if ($urandom_range(0, 99) < idle_pct) idle_for($urandom_range(1, 5));
		send(op, ch);
	endtask

	// Interleave the two strings at random, keeping each one's order
	task automatic load_and_run(int na, int nb, bit wide, int idle_pct);
		logic [7:0] alpha[4];
		logic [7:0] ch;
		int         alpha_size;
		int         ia;
		int         ib;
		bit         pick_a;
		foreach (alpha[i]) alpha[i] = 8'($urandom_range(0, 255));
		alpha_size = $urandom_range(1, 4);
		ia = 0;
		ib = 0;
		while (ia < na || ib < nb) begin
			pick_a = (ib >= nb) || (ia < na && $urandom_range(0, 1));
			ch = wide ? 8'($urandom_range(0, 255)) : alpha[$urandom_range(0, alpha_size - 1)];
			if ($urandom_range(0, 99) < 4)
				step(OP_UNUSED, 8'($urandom_range(0, 255)), idle_pct);
			step(pick_a ? lcs_pkg::OP_APPEND_A : lcs_pkg::OP_APPEND_B, ch, idle_pct);
			if (pick_a) ia++;
			else ib++;
		end
		if ($urandom_range(0, 99) < 8) drain();
		// now and then leave the strings loaded so the next pair piles on top
		if ($urandom_range(0, 99) < 90)
			step(lcs_pkg::OP_RUN, 8'($urandom_range(0, 255)), idle_pct);
	endtask

	initial begin
		int idle_pcts[3];
		int kind;

		idle_pcts = '{0, 59, 7};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// both strings empty
		send(lcs_pkg::OP_RUN, 8'h00);
		// extremes of the byte with a tie on the first mismatch
		send(lcs_pkg::OP_APPEND_A, 8'h00);
		send(lcs_pkg::OP_APPEND_A, 8'hFF);
		send(lcs_pkg::OP_APPEND_B, 8'hFF);
		send(lcs_pkg::OP_APPEND_B, 8'h00);
		send(lcs_pkg::OP_RUN, 8'hFF);
		// unused op is ignored, also between loads
		send(OP_UNUSED, 8'hAA);
		send(lcs_pkg::OP_APPEND_A, 8'h55);
		send(lcs_pkg::OP_APPEND_B, 8'h55);
		send(OP_UNUSED, 8'h55);
		send(lcs_pkg::OP_RUN, 8'h00);
		// one side empty, then the other
		send(lcs_pkg::OP_APPEND_A, 8'h61);
		send(lcs_pkg::OP_APPEND_A, 8'h62);
		send(lcs_pkg::OP_RUN, 8'h00);
		send(lcs_pkg::OP_APPEND_B, 8'h01);
		send(lcs_pkg::OP_RUN, 8'h00);
		// identical strings
		for (int i = 1; i <= 3; i++) send(lcs_pkg::OP_APPEND_A, 8'(i));
		for (int i = 1; i <= 3; i++) send(lcs_pkg::OP_APPEND_B, 8'(i));
		send(lcs_pkg::OP_RUN, 8'h00);
		drain();

		items_sent = 0;
		foreach (idle_pcts[p]) begin
			// full strings, with overflow on the second
			if (p == 2) load_and_run(STR_CAP, STR_CAP + 2, 1'b0, idle_pcts[p]);
			while (items_sent < (p + 1) * ITEMS_PER_PHASE) begin
				kind = $urandom_range(0, 99);
				if (kind < 80)
					load_and_run($urandom_range(0, 8), $urandom_range(0, 8), 1'b0,
						idle_pcts[p]);
				else if (kind < 95)
					load_and_run($urandom_range(0, 12), $urandom_range(0, 12), 1'b1,
						idle_pcts[p]);
				else if ($urandom_range(0, 1))
					load_and_run($urandom_range(50, 70), $urandom_range(0, 6), 1'b0,
						idle_pcts[p]);
				else
					load_and_run($urandom_range(0, 6), $urandom_range(50, 70), 1'b0,
						idle_pcts[p]);
			end
			drain();
		end

		send(lcs_pkg::OP_RUN, 8'h00);
		drain();
		repeat (200) @(posedge clk);

		if (sb.errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

endmodule

[longest_common_subsequence.f]
hdl/lcs_pkg.sv
hdl/lcs_cell.sv
hdl/longest_common_subsequence.sv
verif/longest_common_subsequence_tb.sv
